// ===== rtl/fpa_pkg.sv =====
// package: shared constants, opcodes and beat types for the fixed-point alu
`default_nettype none
package fpa_pkg;

	// configuration
	localparam int FRACTION_BITS = 8;
	localparam int DATA_WIDTH = 32;
	localparam int FIELD_W = 32;
	// datapath width, clamped to the field width
	localparam int EW = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
	// divider numerator / quotient width
	localparam int NW = EW + FRACTION_BITS;
	localparam int DIV_BITS = 2;
	localparam int DIV_STAGES = (NW + DIV_BITS - 1) / DIV_BITS;
	localparam int CNT_W = $clog2(NW + 1);

	// opcodes
	typedef enum logic [3:0] {
		FN_ADD   = 4'd0,
		FN_SUB   = 4'd1,
		FN_MUL   = 4'd2,
		FN_DIV   = 4'd3,
		FN_GT    = 4'd4,
		FN_LT    = 4'd5,
		FN_GE    = 4'd6,
		FN_LE    = 4'd7,
		FN_EQ    = 4'd8,
		FN_NE    = 4'd9,
		FN_MIN   = 4'd10,
		FN_MAX   = 4'd11,
		FN_INC   = 4'd12,
		FN_DEC   = 4'd13,
		FN_TOINT = 4'd14
	} fpa_func_t;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	// saturation bounds
	localparam logic [EW-1:0] EW_MAX = {1'b0, {(EW - 1){1'b1}}};
	localparam logic [EW-1:0] EW_MIN = {1'b1, {(EW - 1){1'b0}}};

	typedef struct packed {
		logic [3:0] func;
		logic signed [FIELD_W-1:0] operand_a;
		logic signed [FIELD_W-1:0] operand_b;
	} fpa_in_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] result_raw;
		logic [1:0] status;
	} fpa_out_t;

	// item state as it moves down the pipeline
	typedef struct packed {
		logic [3:0] func;
		logic neg;
		logic [EW-1:0] res;
		logic [1:0] st;
		logic [NW-1:0] num;
		logic [EW-1:0] rem;
		logic [NW-1:0] quo;
		logic [EW-1:0] den;
		logic [CNT_W-1:0] cnt;
		logic [2*EW-1:0] prod;
	} fpa_work_t;

endpackage
`default_nettype wire

// ===== rtl/fpa_prep.sv =====
// operand decode, direct results of the simple ops and divider/multiplier setup
`default_nettype none
module fpa_prep (
	input  wire fpa_pkg::fpa_in_t in_beat,
	output fpa_pkg::fpa_work_t    work
);
	import fpa_pkg::*;

	logic signed [EW-1:0] a;
	logic signed [EW-1:0] b;
	logic [EW:0] sum;
	logic [EW:0] dif;
	logic [EW:0] incr;
	logic [EW:0] decr;
	logic [EW-1:0] mag_a;
	logic [EW-1:0] mag_b;

	// operands and magnitudes
	always_comb begin
		a = in_beat.operand_a[EW-1:0];
		b = in_beat.operand_b[EW-1:0];
		sum = {a[EW-1], a} + {b[EW-1], b};
		dif = {a[EW-1], a} - {b[EW-1], b};
		incr = {a[EW-1], a} + {{EW{1'b0}}, 1'b1};
		decr = {a[EW-1], a} - {{EW{1'b0}}, 1'b1};
		mag_a = a[EW-1] ? (~a + 1'b1) : a;
		mag_b = b[EW-1] ? (~b + 1'b1) : b;
	end

	// direct results of the simple ops and setup of the long ops
	always_comb begin
		work = '0;
		work.func = in_beat.func;
		work.neg = a[EW-1] ^ b[EW-1];
		work.num = NW'(mag_a) << FRACTION_BITS;
		work.den = mag_b;
		work.st = ST_OK;
		case (in_beat.func)
			FN_ADD: begin
				work.res = sum[EW-1:0];
				if (sum[EW] != sum[EW-1]) begin
					work.res = sum[EW] ? EW_MIN : EW_MAX;
					work.st = ST_OVF;
				end
			end
			FN_SUB: begin
				work.res = dif[EW-1:0];
				if (dif[EW] != dif[EW-1]) begin
					work.res = dif[EW] ? EW_MIN : EW_MAX;
					work.st = ST_OVF;
				end
			end
			FN_INC: begin
				work.res = incr[EW-1:0];
				if (incr[EW] != incr[EW-1]) begin
					work.res = EW_MAX;
					work.st = ST_OVF;
				end
			end
			FN_DEC: begin
				work.res = decr[EW-1:0];
				if (decr[EW] != decr[EW-1]) begin
					work.res = EW_MIN;
					work.st = ST_OVF;
				end
			end
			FN_DIV: begin
				if (b == '0) begin
					work.st = ST_DIV0;
				end
			end
			FN_GT:    work.res = EW'(a > b);
			FN_LT:    work.res = EW'(a < b);
			FN_GE:    work.res = EW'(a >= b);
			FN_LE:    work.res = EW'(a <= b);
			FN_EQ:    work.res = EW'(a == b);
			FN_NE:    work.res = EW'(a != b);
			FN_MIN:   work.res = (a < b) ? a : b;
			FN_MAX:   work.res = (a > b) ? a : b;
			FN_TOINT: work.res = a >>> FRACTION_BITS;
			default:  work.res = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/fpa_mul.sv =====
// magnitude product for the multiply op
`default_nettype none
module fpa_mul (
	input  wire fpa_pkg::fpa_work_t work_in,
	output fpa_pkg::fpa_work_t      work_out
);
	import fpa_pkg::*;

	// top bits of the numerator hold |a|
	always_comb begin
		work_out = work_in;
		work_out.prod = (2 * EW)'(work_in.num[NW-1 -: EW]) * (2 * EW)'(work_in.den);
	end

endmodule
`default_nettype wire

// ===== rtl/fpa_div_step.sv =====
// restoring division, DIV_BITS quotient bits per stage
`default_nettype none
module fpa_div_step (
	input  wire fpa_pkg::fpa_work_t work_in,
	output fpa_pkg::fpa_work_t      work_out
);
	import fpa_pkg::*;

	logic [EW:0] trial;

	always_comb begin
		work_out = work_in;
		trial = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			// skip steps past the last numerator bit
			if (work_out.cnt < CNT_W'(NW)) begin
				trial = {work_out.rem, work_out.num[NW-1]};
				work_out.num = work_out.num << 1;
				if (trial >= {1'b0, work_out.den}) begin
					trial = trial - {1'b0, work_out.den};
					work_out.quo = {work_out.quo[NW-2:0], 1'b1};
				end else begin
					work_out.quo = {work_out.quo[NW-2:0], 1'b0};
				end
				work_out.rem = trial[EW-1:0];
				work_out.cnt = work_out.cnt + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/fpa_finish.sv =====
// rounding, sign and saturation for multiply and divide, result select
`default_nettype none
module fpa_finish (
	input  wire fpa_pkg::fpa_work_t work,
	output fpa_pkg::fpa_out_t       out_beat
);
	import fpa_pkg::*;

	localparam logic [2*EW-1:0] HALF = (FRACTION_BITS > 0) ?
		((2 * EW)'(1) << (FRACTION_BITS - 1)) : '0;

	logic [2*EW-1:0] mul_mag;
	logic [NW:0] div_mag;
	logic [EW-1:0] lim;
	logic [EW-1:0] sat;
	logic [EW-1:0] res;
	logic [1:0] st;

	always_comb begin
		// magnitude bound for the result sign
		lim = work.neg ? EW_MIN : EW_MAX;
		sat = work.neg ? EW_MIN : EW_MAX;
		mul_mag = (work.prod + HALF) >> FRACTION_BITS;
		div_mag = {1'b0, work.quo} + (NW + 1)'({work.rem, 1'b0} >= {1'b0, work.den});
		res = work.res;
		st = work.st;
		case (work.func)
			FN_MUL: begin
				if (mul_mag > (2 * EW)'(lim)) begin
					res = sat;
					st = ST_OVF;
				end else begin
					res = work.neg ? (~mul_mag[EW-1:0] + 1'b1) : mul_mag[EW-1:0];
				end
			end
			FN_DIV: begin
				if (work.st != ST_DIV0) begin
					if (div_mag > (NW + 1)'(lim)) begin
						res = sat;
						st = ST_OVF;
					end else begin
						res = work.neg ? (~div_mag[EW-1:0] + 1'b1) : div_mag[EW-1:0];
					end
				end
			end
			default: ;
		endcase
		out_beat.result_raw = FIELD_W'($signed(res));
		out_beat.status = st;
	end

endmodule
`default_nettype wire

// ===== rtl/fixed_point_alu.sv =====
// top level: pipelined fixed-point alu
// Takes one beat per cycle while the output is not stalled and returns one result beat per
// input beat, in order. The pipe has one decode stage, one multiply stage,
// DIV_STAGES restoring-divider stages of DIV_BITS quotient bits each, and a rounding and
// output stage. The divider chain sets the latency. Every op goes through the full pipe,
// so results leave in input order. A stalled output freezes the whole pipe.
`default_nettype none
module fixed_point_alu (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire fpa_pkg::fpa_in_t   in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output fpa_pkg::fpa_out_t       out_data
);
	import fpa_pkg::*;

	logic adv;
	fpa_work_t prep_w;
	fpa_work_t mul_w;
	fpa_work_t work_s1;
	fpa_work_t work_s2;
	logic valid_s1;
	logic valid_s2;
	// divider stages, s3 onward
	fpa_work_t div_next [DIV_STAGES];
	fpa_work_t div_work_s3 [DIV_STAGES];
	logic [DIV_STAGES-1:0] div_valid_s3;
	fpa_out_t fin_beat;
	fpa_out_t out_sn;
	logic out_valid_sn;

	// whole pipe moves unless a finished beat is held
	assign adv = !(out_valid_sn && out_stall);
	assign in_stall = !adv;

	fpa_prep u_prep (.in_beat(in_data), .work(prep_w));
	fpa_mul u_mul (.work_in(work_s1), .work_out(mul_w));

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			div_valid_s3 <= '0;
			out_valid_sn <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			div_valid_s3 <= {div_valid_s3[DIV_STAGES-2:0], valid_s2};
			out_valid_sn <= div_valid_s3[DIV_STAGES-1];
		end
	end

	// payload of the front stages
	always_ff @(posedge clk) begin
		if (adv) begin
			work_s1 <= prep_w;
			work_s2 <= mul_w;
		end
	end

	// divider chain
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		if (k == 0) begin : g_first
			fpa_div_step u_step (.work_in(work_s2), .work_out(div_next[k]));
		end else begin : g_rest
			fpa_div_step u_step (.work_in(div_work_s3[k-1]), .work_out(div_next[k]));
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_work_s3[k] <= div_next[k];
			end
		end
	end

	fpa_finish u_finish (.work(div_work_s3[DIV_STAGES-1]), .out_beat(fin_beat));

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_sn <= fin_beat;
		end
	end

	assign out_valid = out_valid_sn;
	assign out_data = out_sn;

`ifndef SYNTHESIS
	// status code 3 is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("bad status code");

	// divide by zero returns zero
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_DIV0) |-> out_data.result_raw == '0)
		else $error("divide by zero with nonzero result");

	// saturated results sit at a range bound
	a_ovf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_OVF) |->
		(out_data.result_raw == FIELD_W'($signed(EW_MAX)) ||
		 out_data.result_raw == FIELD_W'($signed(EW_MIN))))
		else $error("overflow result not saturated");

	// the input side stalls only behind a held output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");
`endif

endmodule
`default_nettype wire
